// File: hdl/aspi_pkg.sv
// Shared types, codes, constants and lookup tables of the ADPCM sample player.
`default_nettype none
package aspi_pkg;

	// Sample memory geometry.
	localparam int ROM_DEPTH = 65536;
	localparam int ROM_AW    = $clog2(ROM_DEPTH);

	// Operation codes carried on the input tuser.
	localparam logic [1:0] OP_LOAD  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	// Configuration register indexes.
	localparam logic REG_MASTER_VOLUME = 1'b0;
	localparam logic REG_SAMPLE_STEP   = 1'b1;

	// Reset values of the configuration registers.
	localparam logic [11:0] VOLUME_RESET = 12'd1024;
	localparam logic [14:0] STEP_RESET   = 15'd743;

	// Predictor and step index limits.
	localparam logic signed [13:0] PRED_MAX  = 14'sd2047;
	localparam logic signed [13:0] PRED_MIN  = -14'sd2048;
	localparam logic signed [6:0]  INDEX_MAX = 7'sd48;

	// Output saturation limits.
	localparam logic signed [18:0] SAMPLE_MAX = 19'sd32767;
	localparam logic signed [18:0] SAMPLE_MIN = -19'sd32768;

	// Quantiser step size, floor(16 * 1.1^i) for i = 0..48.
	function automatic logic [10:0] step_size(input logic [5:0] idx);
		logic [10:0] s;
		unique case (idx)
			6'd0:  s = 11'd16;   6'd1:  s = 11'd17;   6'd2:  s = 11'd19;
			6'd3:  s = 11'd21;   6'd4:  s = 11'd23;   6'd5:  s = 11'd25;
			6'd6:  s = 11'd28;   6'd7:  s = 11'd31;   6'd8:  s = 11'd34;
			6'd9:  s = 11'd37;   6'd10: s = 11'd41;   6'd11: s = 11'd45;
			6'd12: s = 11'd50;   6'd13: s = 11'd55;   6'd14: s = 11'd60;
			6'd15: s = 11'd66;   6'd16: s = 11'd73;   6'd17: s = 11'd80;
			6'd18: s = 11'd88;   6'd19: s = 11'd97;   6'd20: s = 11'd107;
			6'd21: s = 11'd118;  6'd22: s = 11'd130;  6'd23: s = 11'd143;
			6'd24: s = 11'd157;  6'd25: s = 11'd173;  6'd26: s = 11'd190;
			6'd27: s = 11'd209;  6'd28: s = 11'd230;  6'd29: s = 11'd253;
			6'd30: s = 11'd279;  6'd31: s = 11'd307;  6'd32: s = 11'd337;
			6'd33: s = 11'd371;  6'd34: s = 11'd408;  6'd35: s = 11'd449;
			6'd36: s = 11'd494;  6'd37: s = 11'd544;  6'd38: s = 11'd598;
			6'd39: s = 11'd658;  6'd40: s = 11'd724;  6'd41: s = 11'd796;
			6'd42: s = 11'd876;  6'd43: s = 11'd963;  6'd44: s = 11'd1060;
			6'd45: s = 11'd1166; 6'd46: s = 11'd1282; 6'd47: s = 11'd1411;
			default: s = 11'd1552;
		endcase
		return s;
	endfunction

	// Step index adjustment by nibble magnitude.
	function automatic logic signed [4:0] index_adjust(input logic [2:0] mag);
		logic signed [4:0] a;
		unique case (mag)
			3'd4:    a = 5'sd2;
			3'd5:    a = 5'sd4;
			3'd6:    a = 5'sd6;
			3'd7:    a = 5'sd8;
			default: a = -5'sd1;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// File: hdl/aspi_rom.sv
// Sample byte memory: one write port for loading, one registered read port for playback.
`default_nettype none
module aspi_rom (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [aspi_pkg::ROM_AW-1:0] wr_addr,
	input  wire logic [7:0]               wr_data,
	input  wire logic                     rd_en,
	input  wire logic [aspi_pkg::ROM_AW-1:0] rd_addr,
	output logic      [7:0]               rd_data
);

	logic [7:0] mem [aspi_pkg::ROM_DEPTH];

	// Load port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Read port with registered data.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// File: hdl/aspi_step.sv
// One ADPCM decode step: predictor and step index update for a single nibble.
`default_nettype none
module aspi_step (
	input  wire logic signed [11:0] pred,
	input  wire logic        [5:0]  idx,
	input  wire logic        [3:0]  nib,
	output logic signed      [11:0] pred_next,
	output logic             [5:0]  idx_next
);

	logic [10:0]        stp;
	logic [11:0]        mag;
	logic signed [13:0] sum;
	logic signed [6:0]  isum;

	// Difference magnitude from the nibble bits, then signed add and clamp.
	always_comb begin
		stp = aspi_pkg::step_size(idx);
		mag = {4'd0, stp[10:3]};
		if (nib[0]) mag = mag + {3'd0, stp[10:2]};
		if (nib[1]) mag = mag + {2'd0, stp[10:1]};
		if (nib[2]) mag = mag + {1'b0, stp};
		if (nib[3]) begin
			sum = {{2{pred[11]}}, pred} - $signed({2'b00, mag});
		end else begin
			sum = {{2{pred[11]}}, pred} + $signed({2'b00, mag});
		end
		priority if (sum > aspi_pkg::PRED_MAX) begin
			pred_next = aspi_pkg::PRED_MAX[11:0];
		end else if (sum < aspi_pkg::PRED_MIN) begin
			pred_next = aspi_pkg::PRED_MIN[11:0];
		end else begin
			pred_next = sum[11:0];
		end
	end

	// Step index adjustment, kept within the table.
	always_comb begin
		isum = $signed({1'b0, idx}) + 7'(aspi_pkg::index_adjust(nib[2:0]));
		priority if (isum > aspi_pkg::INDEX_MAX) begin
			idx_next = aspi_pkg::INDEX_MAX[5:0];
		end else if (isum < 7'sd0) begin
			idx_next = 6'd0;
		end else begin
			idx_next = isum[5:0];
		end
	end

endmodule
`default_nettype wire

// File: hdl/aspi_mul.sv
// Shared signed multiplier with registered product, used for gain and interpolation.
`default_nettype none
module aspi_mul (
	input  wire logic               clk,
	input  wire logic               en,
	input  wire logic signed [17:0] a,
	input  wire logic signed [12:0] b,
	output logic signed      [30:0] p_q
);

	// Product is captured only when the sequencer asks, so it holds for the next state.
	always_ff @(posedge clk) begin
		if (en) begin
			p_q <= 31'(a * b);
		end
	end

endmodule
`default_nettype wire

// File: hdl/adpcm_sample_player_interp_unit.sv
// Top level of the ADPCM sample player: stream ports, sequencer and state registers.
// Load and start beats do not hold the input off. A tick beat holds the input off while
// the sequencer works on it: for each of the n (1 to 8) whole nibbles that the phase
// calls for, a sample memory read in the decode state and then the shared decode step;
// a nibble past the end of the sample takes the decode state only. One more decode pass
// closes the loop, and the gain and interpolation products then go through one shared
// multiplier in turn. A tick with less than a whole nibble of phase skips decoding and
// gain. A new beat is taken while a finished sample still waits on the master side, and
// a tick then waits at its last state for the output register. Input tuser holds the
// operation (0 load, 1 start, 2 tick); tdata holds address, ROM byte and nibble count. A
// start with nibble count of 0x80000 or more is ignored. The 64 KiB sample memory has no
// reset; reading an unloaded byte gives an undefined nibble. Configuration index 0 is
// master volume (1024 is unity gain), index 1 is the phase increment per tick in units
// of 1/4096 of a nibble.
`default_nettype none
module adpcm_sample_player_interp_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [47:0] s_tdata,   // address[15:0], rom_byte[23:16], nibble_count[43:24]
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,   // sample[15:0], playing[16]
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [14:0] cfg_data
);

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DEC    = 3'd1;
	localparam logic [2:0] ST_STEP   = 3'd2;
	localparam logic [2:0] ST_VOL    = 3'd3;
	localparam logic [2:0] ST_VOLW   = 3'd4;
	localparam logic [2:0] ST_INTERP = 3'd5;
	localparam logic [2:0] ST_INTW   = 3'd6;

	logic [2:0]         state_q;
	logic [11:0]        vol_q;
	logic [14:0]        step_q;
	logic [15:0]        phase_q;
	logic signed [11:0] v_q;
	logic signed [11:0] pred_q;
	logic [5:0]         idx_q;
	logic [15:0]        base_q;
	logic [16:0]        pos_q;
	logic [18:0]        left_q;
	logic               active_q;
	logic [7:0]         held_q;
	logic               fetch_q;
	logic signed [16:0] prev_q;
	logic signed [16:0] cur_q;
	logic               m_tvalid_q;
	logic [23:0]        m_tdata_q;

	logic        [1:0]  in_op;
	logic        [15:0] in_addr;
	logic        [7:0]  in_byte;
	logic        [19:0] in_count;
	logic               in_beat;
	logic               out_free;
	logic [15:0]        fetch_addr;
	logic [7:0]         rom_data;
	logic [3:0]         nib;
	logic signed [11:0] pred_next;
	logic [5:0]         idx_next;
	logic               mul_en;
	logic signed [17:0] mul_a;
	logic signed [12:0] mul_b;
	logic signed [30:0] prod;
	logic signed [30:0] vol_round;
	logic signed [18:0] interp;
	logic signed [15:0] sample_sat;

	assign in_op    = s_tuser;
	assign in_addr  = s_tdata[15:0];
	assign in_byte  = s_tdata[23:16];
	assign in_count = s_tdata[43:24];

	assign s_tready  = (state_q == ST_IDLE);
	assign in_beat   = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_tvalid_q || m_tready;
	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_tdata_q;

	// Sample memory: loads come straight from the input beat, reads from the decode loop.
	assign fetch_addr = base_q + pos_q[16:1];

	aspi_rom u_rom (
		.clk     (clk),
		.wr_en   (in_beat && (in_op == aspi_pkg::OP_LOAD)),
		.wr_addr (in_addr[aspi_pkg::ROM_AW-1:0]),
		.wr_data (in_byte),
		.rd_en   (state_q == ST_DEC),
		.rd_addr (fetch_addr[aspi_pkg::ROM_AW-1:0]),
		.rd_data (rom_data)
	);

	// High nibble of a freshly read byte, else the low nibble of the held one.
	assign nib = fetch_q ? rom_data[7:4] : held_q[3:0];

	aspi_step u_step (
		.pred      (pred_q),
		.idx       (idx_q),
		.nib       (nib),
		.pred_next (pred_next),
		.idx_next  (idx_next)
	);

	// Multiplier operands: gain in the volume state, slope times phase in the interpolation state.
	always_comb begin
		mul_en = 1'b0;
		mul_a  = {{6{v_q[11]}}, v_q};
		mul_b  = $signed({1'b0, vol_q});
		if (state_q == ST_VOL) begin
			mul_en = 1'b1;
		end else if (state_q == ST_INTERP) begin
			mul_en = 1'b1;
			mul_a  = {cur_q[16], cur_q} - {prev_q[16], prev_q};
			mul_b  = $signed({1'b0, phase_q[11:0]});
		end
	end

	aspi_mul u_mul (
		.clk (clk),
		.en  (mul_en),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	// Gain result divided by 256 toward zero; interpolated sample with saturation.
	always_comb begin
		vol_round = prod[30] ? (prod + 31'sd255) : prod;
		interp    = {{2{prev_q[16]}}, prev_q} + prod[30:12];
		priority if (interp > aspi_pkg::SAMPLE_MAX) begin
			sample_sat = aspi_pkg::SAMPLE_MAX[15:0];
		end else if (interp < aspi_pkg::SAMPLE_MIN) begin
			sample_sat = aspi_pkg::SAMPLE_MIN[15:0];
		end else begin
			sample_sat = interp[15:0];
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vol_q  <= aspi_pkg::VOLUME_RESET;
			step_q <= aspi_pkg::STEP_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				aspi_pkg::REG_MASTER_VOLUME: vol_q  <= cfg_data[11:0];
				aspi_pkg::REG_SAMPLE_STEP:   step_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and playback state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			phase_q    <= '0;
			v_q        <= '0;
			pred_q     <= '0;
			idx_q      <= '0;
			base_q     <= '0;
			pos_q      <= '0;
			left_q     <= '0;
			active_q   <= 1'b0;
			held_q     <= '0;
			fetch_q    <= 1'b0;
			prev_q     <= '0;
			cur_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready && !((state_q == ST_INTW) && out_free)) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_beat && (in_op == aspi_pkg::OP_START) && !in_count[19]) begin
						base_q   <= in_addr;
						pos_q    <= '0;
						left_q   <= in_count[18:0];
						pred_q   <= '0;
						idx_q    <= '0;
						active_q <= 1'b1;
					end else if (in_beat && (in_op == aspi_pkg::OP_TICK)) begin
						v_q <= '0;
						if (phase_q[15:12] != 4'd0) begin
							prev_q  <= cur_q;
							state_q <= ST_DEC;
						end else begin
							state_q <= ST_INTERP;
						end
					end
				end
				ST_DEC: begin
					// One nibble per pass while a whole nibble of phase remains.
					if (phase_q[15:12] == 4'd0) begin
						state_q <= ST_VOL;
					end else if (!active_q) begin
						v_q     <= '0;
						phase_q <= phase_q - 16'h1000;
					end else if (left_q == '0) begin
						active_q <= 1'b0;
						v_q      <= '0;
						phase_q  <= phase_q - 16'h1000;
					end else begin
						fetch_q <= !pos_q[0];
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (fetch_q) begin
						held_q <= rom_data;
					end
					pred_q  <= pred_next;
					idx_q   <= idx_next;
					v_q     <= pred_next;
					pos_q   <= pos_q + 17'd1;
					left_q  <= left_q - 19'd1;
					phase_q <= phase_q - 16'h1000;
					state_q <= ST_DEC;
				end
				ST_VOL: begin
					state_q <= ST_VOLW;
				end
				ST_VOLW: begin
					cur_q   <= vol_round[24:8];
					state_q <= ST_INTERP;
				end
				ST_INTERP: begin
					state_q <= ST_INTW;
				end
				ST_INTW: begin
					if (out_free) begin
						m_tvalid_q <= 1'b1;
						phase_q    <= phase_q + {1'b0, step_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if ((state_q == ST_INTW) && out_free) begin
			m_tdata_q <= {7'd0, active_q, sample_sat};
		end
	end

	// The step index stays inside the step size table.
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= aspi_pkg::INDEX_MAX[5:0])
		else $error("step index beyond table");

	// Interpolation only runs once the phase is below one whole nibble.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INTERP) |-> (phase_q[15:12] == 4'd0))
		else $error("interpolation with whole nibble of phase left");

	// A new output beat comes only from the last state of a tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && !$past(m_tvalid_q)) |-> ($past(state_q) == ST_INTW))
		else $error("output beat without tick");

	// An accepted start with a valid count arms playback.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_beat && (in_op == aspi_pkg::OP_START) && !in_count[19]) |=> active_q)
		else $error("start did not arm playback");

	// A decode step is always preceded by the decision pass.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_STEP) |-> ($past(state_q) == ST_DEC))
		else $error("decode step out of sequence");

endmodule
`default_nettype wire

// File: tb/adpcm_sample_player_interp_unit_checker.sv
// Checker for the ADPCM sample player: mirrors its state, forecasts each tick's sample, compares.
module adpcm_sample_player_interp_unit_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	input  wire logic        s_tready,
	input  wire logic [47:0] s_tdata,   // address[15:0], rom_byte[23:16], nibble_count[43:24]
	input  wire logic [1:0]  s_tuser,   // operation[1:0]
	input  wire logic        m_tvalid,
	input  wire logic        m_tready,
	input  wire logic [23:0] m_tdata,   // sample[15:0], playing[16]
	input  wire logic        cfg_valid,
	input  wire logic        cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [14:0] cfg_data,
	output int               error_count,
	output int               samples_due_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [15:0] value;
		logic        playing;
	} tick_beat_t;

	// Quantiser step sizes, floor(16 * 1.1^i).
	int step_lut [0:48] = '{
		16, 17, 19, 21, 23, 25, 28, 31, 34, 37, 41, 45, 50, 55, 60, 66,
		73, 80, 88, 97, 107, 118, 130, 143, 157, 173, 190, 209, 230, 253, 279, 307,
		337, 371, 408, 449, 494, 544, 598, 658, 724, 796, 876, 963, 1060, 1166, 1282, 1411,
		1552
	};

	// Mirror of the configuration and of the playback state.
	bit [7:0]  rom_mem [0:aspi_pkg::ROM_DEPTH-1];
	bit [11:0] gain       = aspi_pkg::VOLUME_RESET;
	bit [14:0] phase_inc  = aspi_pkg::STEP_RESET;
	bit [15:0] play_base  = '0;
	bit [16:0] nib_pos    = '0;
	bit [18:0] nib_left   = '0;
	bit        is_playing = 1'b0;
	bit [7:0]  held_byte  = '0;
	int        pred       = 0;
	int        step_idx   = 0;
	bit [15:0] phase_acc  = '0;
	int        prev_level = 0;
	int        cur_level  = 0;

	tick_beat_t samples_due [$];
	int         errors = 0;

	assign error_count = errors;

	task automatic flag_error(input string what);
		$display("ERROR at %0t ns: %s", $time, what);
		errors++;
	endtask

	// One nibble decode; gives the unscaled level, predictor times 64, or zero when silent.
	function automatic int decode_nibble();
		bit [3:0]  nib;
		bit [15:0] fetch_addr;
		int        stp;
		int        delta;
		if (!is_playing)
			return 0;
		if (nib_left == 0) begin
			is_playing = 1'b0;
			return 0;
		end
		nib_left--;
		if (nib_pos[0]) begin
			nib = held_byte[3:0];
		end else begin
			fetch_addr = play_base + nib_pos[16:1];
			held_byte  = rom_mem[fetch_addr];
			nib        = held_byte[7:4];
		end
		stp   = step_lut[step_idx];
		delta = stp >> 3;
		if (nib[0]) delta += stp >> 2;
		if (nib[1]) delta += stp >> 1;
		if (nib[2]) delta += stp;
		if (nib[3]) delta = -delta;
		pred += delta;
		if (pred > 2047) pred = 2047;
		if (pred < -2048) pred = -2048;
		// Large magnitudes widen the step by 2, 4, 6 or 8; small ones narrow it by one.
		if (nib[2]) step_idx += 2 * int'(nib[1:0]) + 2;
		else step_idx -= 1;
		if (step_idx > 48) step_idx = 48;
		if (step_idx < 0) step_idx = 0;
		nib_pos++;
		return pred * 64;
	endfunction

	// Advances the phase by one output tick and queues the interpolated sample.
	task automatic forecast_tick_sample();
		int         raw;
		longint     diff;
		longint     level;
		tick_beat_t beat;
		if (phase_acc >= 16'h1000) begin
			raw        = 0;
			prev_level = cur_level;
			while (phase_acc >= 16'h1000) begin
				raw = decode_nibble();
				phase_acc -= 16'h1000;
			end
			cur_level = int'((longint'(raw) * longint'(gain)) / 16384);
		end
		diff  = longint'(cur_level - prev_level) * longint'(phase_acc);
		level = longint'(prev_level) + (diff >>> 12);
		if (level > 32767) level = 32767;
		if (level < -32768) level = -32768;
		phase_acc     = phase_acc + 16'(phase_inc);
		beat.value    = 16'(level);
		beat.playing  = is_playing;
		samples_due.push_back(beat);
	endtask

	// Watch all three channels at each rising edge; results first, as they belong to older ticks.
	always @(posedge clk) begin : watch_channels
		tick_beat_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (samples_due.size() == 0) begin
					flag_error($sformatf("output beat 0x%06h with no tick waiting", m_tdata));
				end else begin
					want = samples_due.pop_front();
					if (m_tdata[15:0] !== want.value)
						flag_error($sformatf("sample %0d, expected %0d",
							$signed(m_tdata[15:0]), $signed(want.value)));
					if (m_tdata[16] !== want.playing)
						flag_error($sformatf("playing %b, expected %b",
							m_tdata[16], want.playing));
				end
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == aspi_pkg::REG_MASTER_VOLUME) gain = cfg_data[11:0];
				else phase_inc = cfg_data;
			end
			if (s_tvalid && s_tready) begin
				case (s_tuser)
					aspi_pkg::OP_LOAD: begin
						rom_mem[s_tdata[15:0]] = s_tdata[23:16];
					end
					aspi_pkg::OP_START: begin
						// Counts of 0x80000 and above leave playback untouched.
						if (s_tdata[43:24] < 20'h80000) begin
							play_base  = s_tdata[15:0];
							nib_pos    = '0;
							nib_left   = s_tdata[42:24];
							pred       = 0;
							step_idx   = 0;
							is_playing = 1'b1;
						end
					end
					aspi_pkg::OP_TICK: begin
						forecast_tick_sample();
					end
					default: begin
					end
				endcase
			end
		end
		samples_due_count = samples_due.size();
	end

endmodule

// File: tb/adpcm_sample_player_interp_unit_test.sv
// Testbench top for the ADPCM sample player: clock, reset, stimulus, back-pressure and verdict.
module adpcm_sample_player_interp_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [1:0] OP_UNUSED   = 2'd3;
	localparam int         CYCLE_LIMIT = 500000;
	localparam int         SETTLE      = 40;
	localparam int         HOLD_CYCLES = 400;
	localparam int         PHASE_ITEMS = 230;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata   = '0;   // address[15:0], rom_byte[23:16], nibble_count[43:24]
	logic [1:0]  s_tuser   = '0;   // operation[1:0]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;          // sample[15:0], playing[16]
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_index = 1'b0;
	logic [14:0] cfg_data  = '0;

	int        error_count;
	int        samples_due_count;
	int        cycle_count  = 0;
	int        items_sent   = 0;
	int        tx_idle_pct  = 0;
	int        rx_stall_pct = 0;
	bit        hold_request = 1'b0;
	bit [14:0] cur_step     = aspi_pkg::STEP_RESET;

	adpcm_sample_player_interp_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	adpcm_sample_player_interp_unit_checker sample_check (
		.clk               (clk),
		.arst_n            (arst_n),
		.s_tvalid          (s_tvalid),
		.s_tready          (s_tready),
		.s_tdata           (s_tdata),
		.s_tuser           (s_tuser),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.m_tdata           (m_tdata),
		.cfg_valid         (cfg_valid),
		.cfg_ready         (cfg_ready),
		.cfg_index         (cfg_index),
		.cfg_data          (cfg_data),
		.error_count       (error_count),
		.samples_due_count (samples_due_count)
	);

	// 100 MHz clock.
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("adpcm_sample_player_interp_unit: mismatch");
			$finish;
		end
	end

	// Output side: random stalls, plus one long hold-off when asked for.
	initial begin : output_side
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_left    = HOLD_CYCLES;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Offers one beat, after a random idle gap, and returns at the falling edge after it is taken.
	task automatic send_item(input logic [1:0] op, input logic [15:0] addr,
			input logic [7:0] data_byte, input logic [19:0] count);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'd0, count, data_byte, addr};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		if (!(op == OP_UNUSED || (op == aspi_pkg::OP_START && count >= 20'h80000)))
			items_sent++;
	endtask

	// Writes both registers; called only while the block is idle.
	task automatic set_config(input logic [11:0] vol, input logic [14:0] stp);
		cfg_valid <= 1'b1;
		cfg_index <= aspi_pkg::REG_MASTER_VOLUME;
		cfg_data  <= {3'd0, vol};
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_index <= aspi_pkg::REG_SAMPLE_STEP;
		cfg_data  <= stp;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		cur_step  = stp;
	endtask

	// Lets every outstanding sample arrive, then gives the block time to go quiet.
	task automatic drain();
		s_tvalid <= 1'b0;
		rx_stall_pct = 0;
		while (samples_due_count != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	// A beat the block should ignore, or a stray load.
	task automatic send_noise();
		case ($urandom_range(2))
			0: send_item(OP_UNUSED, 16'($urandom), 8'($urandom), 20'($urandom));
			1: send_item(aspi_pkg::OP_START, 16'($urandom), 8'($urandom),
				20'h80000 | 20'($urandom));
			default: send_item(aspi_pkg::OP_LOAD, 16'($urandom), 8'($urandom), 20'($urandom));
		endcase
	endtask

	// Loads a sample region, starts it and ticks through it. Only the bytes that the ticks
	// can reach are loaded, bounded by the phase carried in plus the increment per tick.
	task automatic play_song();
		int          ticks;
		int          reach;
		int          nbytes;
		int          style;
		int          pick;
		logic [15:0] base;
		logic [19:0] count;
		logic [7:0]  data_byte;
		ticks = $urandom_range(1, 40);
		pick  = $urandom_range(99);
		if (pick < 12) count = '0;
		else if (pick < 70) count = 20'($urandom_range(1, 4 * ticks));
		else count = 20'($urandom_range(20'h7FFFF));
		reach = 5 + ((ticks * int'(cur_step)) >> 12);
		if (count < reach) reach = int'(count);
		nbytes = reach / 2 + 1;
		base   = 16'($urandom);
		style  = $urandom_range(3);
		for (int i = 0; i < nbytes; i++) begin
			if ($urandom_range(19) == 0) send_noise();
			// Runs of 0x77 drive the predictor to its top, runs of 0xFF to its bottom.
			case (style)
				2: data_byte = 8'h77;
				3: data_byte = 8'hFF;
				default: data_byte = 8'($urandom);
			endcase
			send_item(aspi_pkg::OP_LOAD, base + 16'(i), data_byte, 20'($urandom));
		end
		send_item(aspi_pkg::OP_START, base, 8'($urandom), count);
		for (int t = 0; t < ticks; t++) begin
			if ($urandom_range(9) == 0) send_noise();
			send_item(aspi_pkg::OP_TICK, 16'($urandom), 8'($urandom), 20'($urandom));
		end
	endtask

	// Main sequence.
	initial begin : stimulus
		logic [11:0] vol;
		logic [14:0] stp;
		int          target;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed beats: address wrap, ignored and edge counts, unused code, end of sample.
		set_config(12'd4095, 15'd8192);
		send_item(aspi_pkg::OP_LOAD, 16'hFFFF, 8'h80, 20'hFFFFF);
		send_item(aspi_pkg::OP_LOAD, 16'h0000, 8'h7F, 20'h00000);
		send_item(aspi_pkg::OP_LOAD, 16'h0001, 8'h08, 20'h00000);
		send_item(aspi_pkg::OP_LOAD, 16'h0002, 8'hF7, 20'h00000);
		send_item(OP_UNUSED, 16'hFFFF, 8'hFF, 20'hFFFFF);
		send_item(aspi_pkg::OP_START, 16'hFFFF, 8'h00, 20'h80000);
		send_item(aspi_pkg::OP_START, 16'h0000, 8'hFF, 20'hFFFFF);
		send_item(aspi_pkg::OP_TICK, 16'h0000, 8'h00, 20'h00000);
		send_item(aspi_pkg::OP_TICK, 16'hFFFF, 8'hFF, 20'hFFFFF);
		send_item(aspi_pkg::OP_START, 16'hFFFF, 8'h00, 20'h7FFFF);
		repeat (3) send_item(aspi_pkg::OP_TICK, 16'h0000, 8'h00, 20'h00000);
		send_item(aspi_pkg::OP_START, 16'h0002, 8'h00, 20'h00000);
		send_item(aspi_pkg::OP_TICK, 16'h0000, 8'h00, 20'h00000);
		send_item(aspi_pkg::OP_START, 16'h0002, 8'h00, 20'h00001);
		repeat (2) send_item(aspi_pkg::OP_TICK, 16'h0000, 8'h00, 20'h00000);
		drain();

		// Random phases, each with its own register settings and idling pattern.
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin vol = 12'd4095; stp = 15'd16384; end
				1: begin vol = 12'd0;    stp = 15'd1;     end
				3: begin vol = 12'd1024; stp = 15'd4096;  end
				5: begin vol = 12'($urandom_range(4095)); stp = aspi_pkg::STEP_RESET; end
				default: begin
					vol = 12'($urandom_range(4095));
					stp = 15'($urandom_range(1, 16384));
				end
			endcase
			set_config(vol, stp);
			case (ph)
				1, 5: begin tx_idle_pct = 65; rx_stall_pct = 0;  end
				2:    begin tx_idle_pct = 0;  rx_stall_pct = 65; end
				3:    begin tx_idle_pct = 16; rx_stall_pct = 16; end
				default: begin tx_idle_pct = 0; rx_stall_pct = 0; end
			endcase
			// The first phase opens with a long hold-off on the output side.
			if (ph == 0) hold_request = 1'b1;
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) play_song();
			tx_idle_pct = 0;
			drain();
		end

		if (error_count == 0 && samples_due_count == 0) begin
			$display("adpcm_sample_player_interp_unit: match");
		end else begin
			$display("adpcm_sample_player_interp_unit: mismatch");
		end
		$finish;
	end

endmodule

// File: sim.f
hdl/aspi_pkg.sv
hdl/aspi_rom.sv
hdl/aspi_step.sv
hdl/aspi_mul.sv
hdl/adpcm_sample_player_interp_unit.sv
tb/adpcm_sample_player_interp_unit_checker.sv
tb/adpcm_sample_player_interp_unit_test.sv
